// ===== rtl/bgms_pkg.sv =====
`timescale 1ns / 1ps

package bgms_pkg;

  localparam int GRID_SIDE_DEFAULT = 64;

  localparam int OP_W     = 2;
  localparam int COORD_W  = 6;
  localparam int COUNT_W  = 4;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_SMOOTH = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

  localparam logic               TARGET_RESET    = 1'b1;
  localparam logic [CFG_W-1:0]   THRESHOLD_RESET = 4'd4;

  localparam logic [1:0] ROW_UP   = 2'd0;
  localparam logic [1:0] ROW_MID  = 2'd1;
  localparam logic [1:0] ROW_DOWN = 2'd2;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic [1:0] rd_row;
    logic       acc_en;
    logic [1:0] acc_row;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/bgms_ram.sv =====
`timescale 1ns / 1ps

module bgms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/bgms_ctrl.sv =====
`timescale 1ns / 1ps

module bgms_ctrl
  import bgms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RD_UP  = 3'd2;
  localparam logic [2:0] S_RD_MID = 3'd3;
  localparam logic [2:0] S_RD_DN  = 3'd4;
  localparam logic [2:0] S_LAST   = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.rd_row  = ROW_MID;
    cmd.acc_row = ROW_MID;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RD_UP;
        end
      end
      S_RD_UP: begin
        cmd.rd_row = ROW_UP;
        state_next = S_RD_MID;
      end
      S_RD_MID: begin
        cmd.rd_row  = ROW_MID;
        cmd.acc_en  = 1'b1;
        cmd.acc_row = ROW_UP;
        state_next  = S_RD_DN;
      end
      S_RD_DN: begin
        cmd.rd_row  = ROW_DOWN;
        cmd.acc_en  = 1'b1;
        cmd.acc_row = ROW_MID;
        state_next  = S_LAST;
      end
      S_LAST: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_row = ROW_DOWN;
        state_next  = S_COMMIT;
      end
      S_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_commit_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !in_stall)
    else $error("commit not followed by idle");

  a_load_starts_read: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (cmd.rd_row == ROW_UP) && !cmd.acc_en)
    else $error("accepted request did not start neighbor reads");

  a_clear_only_after_reset: assert property (@(posedge clk) disable iff (rst)
    (cmd.clear && !$past(rst)) |-> $past(cmd.clear))
    else $error("clearing pass entered outside reset");
`endif

endmodule

// ===== rtl/bgms_datapath.sv =====
`timescale 1ns / 1ps

module bgms_datapath
  import bgms_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [OP_W-1:0]      op,
  input  logic [COORD_W-1:0]   col,
  input  logic [COORD_W-1:0]   row,
  input  logic                 write_bit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 cell_bit,
  output logic [COUNT_W-1:0]   match_count
);

  localparam int AW = $clog2(GRID_SIDE);

  logic                 target_value;
  logic [CFG_W-1:0]     majority_threshold;

  logic [OP_W-1:0]      op_q;
  logic [COORD_W-1:0]   col_q;
  logic [COORD_W-1:0]   row_q;
  logic                 wbit_q;
  logic [COUNT_W-1:0]   count_q;
  logic [GRID_SIDE-1:0] mid_word;
  logic [AW-1:0]        clear_cnt;

  logic [31:0]          col_ext;
  logic [31:0]          row_ext;
  logic [AW-1:0]        col_a;
  logic [AW-1:0]        row_a;
  logic                 in_range;
  logic                 has_left;
  logic                 has_right;
  logic                 has_up;
  logic                 has_down;
  logic [AW-1:0]        idx_l;
  logic [AW-1:0]        idx_r;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [GRID_SIDE-1:0] ram_wdata;
  logic [GRID_SIDE-1:0] ram_rdata;

  logic                 row_ok;
  logic                 bit_l;
  logic                 bit_c;
  logic                 bit_r;
  logic [COUNT_W-1:0]   row_matches;
  logic                 is_smooth;
  logic                 is_write;
  logic                 new_bit;
  logic [GRID_SIDE-1:0] new_word;

  bgms_ram #(
    .WIDTH(GRID_SIDE),
    .DEPTH(GRID_SIDE)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign col_ext   = 32'(col_q);
  assign row_ext   = 32'(row_q);
  assign col_a     = col_ext[AW-1:0];
  assign row_a     = row_ext[AW-1:0];
  assign in_range  = (col_ext < 32'(GRID_SIDE)) && (row_ext < 32'(GRID_SIDE));
  assign has_left  = (col_ext != 32'd0);
  assign has_right = ((col_ext + 32'd1) < 32'(GRID_SIDE));
  assign has_up    = (row_ext != 32'd0);
  assign has_down  = ((row_ext + 32'd1) < 32'(GRID_SIDE));
  assign idx_l     = has_left ? (col_a - AW'(1)) : col_a;
  assign idx_r     = has_right ? (col_a + AW'(1)) : col_a;

  assign is_smooth = (op_q == OP_SMOOTH);
  assign is_write  = (op_q == OP_WRITE);

  // neighbor window of the row word that just came out of the ram
  always_comb begin
    case (cmd.acc_row)
      ROW_UP:   row_ok = has_up;
      ROW_DOWN: row_ok = has_down;
      default:  row_ok = 1'b1;
    endcase
    bit_l = has_left && (ram_rdata[idx_l] == target_value);
    bit_r = has_right && (ram_rdata[idx_r] == target_value);
    bit_c = (cmd.acc_row != ROW_MID) && (ram_rdata[col_a] == target_value);
    row_matches = row_ok ? ({3'b000, bit_l} + {3'b000, bit_c} + {3'b000, bit_r})
                         : '0;
  end

  always_comb begin
    if (!in_range) begin
      new_bit = 1'b0;
    end else if (is_write) begin
      new_bit = wbit_q;
    end else if (is_smooth) begin
      new_bit = (count_q >= majority_threshold) ? target_value : !target_value;
    end else begin
      new_bit = mid_word[col_a];
    end
    new_word        = mid_word;
    new_word[col_a] = new_bit;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = new_word;
    case (cmd.rd_row)
      ROW_UP:   ram_addr = has_up ? (row_a - AW'(1)) : row_a;
      ROW_DOWN: ram_addr = has_down ? (row_a + AW'(1)) : row_a;
      default:  ram_addr = row_a;
    endcase
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_addr  = clear_cnt;
      ram_wdata = '0;
    end else if (cmd.commit) begin
      ram_we = in_range && (is_write || is_smooth);
    end
  end

  assign status.clear_done = (clear_cnt == AW'(GRID_SIDE - 1));
  assign status.out_free   = !out_valid || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_value       <= TARGET_RESET;
      majority_threshold <= THRESHOLD_RESET;
      clear_cnt          <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_write && (cfg_index == REG_TARGET)) begin
        target_value <= cfg_data[0];
      end
      if (cfg_write && (cfg_index == REG_THRESHOLD)) begin
        majority_threshold <= cfg_data;
      end
      if (cmd.clear && !status.clear_done) begin
        clear_cnt <= clear_cnt + AW'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op;
      col_q   <= col;
      row_q   <= row;
      wbit_q  <= write_bit;
      count_q <= '0;
    end else if (cmd.acc_en) begin
      count_q <= count_q + row_matches;
    end
    if (cmd.acc_en && (cmd.acc_row == ROW_MID)) begin
      mid_word <= ram_rdata;
    end
    if (cmd.commit) begin
      cell_bit    <= new_bit;
      match_count <= (in_range && is_smooth) ? count_q : '0;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (match_count <= COUNT_W'(8)))
    else $error("match count above eight");

  a_count_only_on_smooth: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !is_smooth) |=> (match_count == '0))
    else $error("nonzero match count on write or read");

  a_no_write_while_gathering: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_en |-> !ram_we)
    else $error("grid written while neighbors are gathered");
`endif

endmodule

// ===== rtl/binary_grid_majority_smoother_top.sv =====
`timescale 1ns / 1ps

// Majority smoother over a GRID_SIDE x GRID_SIDE grid of one-bit cells kept in a
// single-port ram, one grid row per word. After reset the block runs a clearing pass over all
// GRID_SIDE rows (one row a cycle) with in_stall high; configuration writes are taken
// during it. Every request (write, read or smooth) is then worked through before the next is
// accepted: three row reads on the one ram port, the neighbor count, and one row write-back
// for writes and smooths, which also orders in-place updates; the result is presented once the
// output register is free. The next request is accepted in the cycle after a result is loaded
// into the output register, even while that result is still stalled.

module binary_grid_majority_smoother_top
  import bgms_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      op,
  input  logic [COORD_W-1:0]   col,
  input  logic [COORD_W-1:0]   row,
  input  logic                 write_bit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 cell_bit,
  output logic [COUNT_W-1:0]   match_count
);

  cmd_t    cmd;
  status_t status;

  bgms_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  bgms_datapath #(
    .GRID_SIDE(GRID_SIDE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op         (op),
    .col        (col),
    .row        (row),
    .write_bit  (write_bit),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_bit   (cell_bit),
    .match_count(match_count)
  );

endmodule
